@@ rtl/ipv4p_pkg.sv @@
// Shared types, character codes and field placement for the IPv4 text parser.
package ipv4p_pkg;

    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [7:0]  CHAR_DOT   = 8'h2E;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [1:0]  FIELD_LAST = 2'd3;
    localparam logic [15:0] FIELD_SAT  = 16'hFFFF;

    typedef struct packed {
        logic [7:0] text_char;
        logic       final_char;
    } t_item;

    typedef struct packed {
        logic [31:0] address;
        logic        invalid;
    } t_result;

    // Field 0 lands in bits 31..24; upper bits of a big field 0 wrap off the top.
    function automatic logic [31:0] place_field(input logic [15:0] value,
                                                input logic [1:0]  number);
        logic [31:0] placed;
        placed = '0;
        case (number)
            2'd0:    placed = {value[7:0], 24'h000000};
            2'd1:    placed = {value, 16'h0000};
            2'd2:    placed = {8'h00, value, 8'h00};
            default: placed = {16'h0000, value};
        endcase
        return placed;
    endfunction

endpackage

@@ rtl/ipv4p_in_stage.sv @@
// Input register holding one character transfer until the parser core takes it.
module ipv4p_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ipv4p_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_stall,
    output logic            o_full,
    output ipv4p_pkg::t_item o_item
);
    import ipv4p_pkg::*;

    logic  r_full;
    logic  n_full;
    t_item r_item;
    logic  load;

    // Free slot, or the held item leaves this cycle.
    assign o_stall = r_full && !i_take;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_full = r_full;
        if (load) begin
            n_full = 1'b1;
        end else if (i_take) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_full = r_full;
    assign o_item = r_item;

endmodule

@@ rtl/ipv4p_core.sv @@
// Parser state and the single-pass per-character update.
module ipv4p_core #(
    parameter int MAX_CHARS = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  ipv4p_pkg::t_item   i_item,
    output ipv4p_pkg::t_result o_result
);
    import ipv4p_pkg::*;

    localparam int         CNT_W   = $clog2(MAX_CHARS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

    logic [15:0]      r_value,   n_value;
    logic [1:0]       r_number,  n_number;
    logic             r_stopped, n_stopped;
    logic [31:0]      r_sum,     n_sum;
    logic [CNT_W-1:0] r_chars,   n_chars;

    logic [19:0] times_ten;
    logic        is_digit;
    logic        is_dot;

    assign is_digit  = (i_item.text_char >= CHAR_ZERO) && (i_item.text_char <= CHAR_NINE);
    assign is_dot    = (i_item.text_char == CHAR_DOT);
    // value * 10 + digit; the digit is the low nibble of '0'..'9'
    assign times_ten = ({4'h0, r_value} << 3) + ({4'h0, r_value} << 1)
                     + {16'h0000, i_item.text_char[3:0]};

    always_comb begin
        n_value   = r_value;
        n_number  = r_number;
        n_stopped = r_stopped;
        n_sum     = r_sum;
        n_chars   = r_chars;
        if (r_chars < MAX_CNT) begin
            if (i_item.text_char == CHAR_NUL) begin
                n_chars = MAX_CNT;
            end else begin
                n_chars = r_chars + 1'b1;
                if (is_dot && (r_number != FIELD_LAST)) begin
                    n_sum     = r_sum + place_field(r_value, r_number);
                    n_number  = r_number + 1'b1;
                    n_value   = '0;
                    n_stopped = 1'b0;
                end else if (!r_stopped && is_digit) begin
                    n_value = (times_ten[19:16] != 4'h0) ? FIELD_SAT : times_ten[15:0];
                end else begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (n_number == FIELD_LAST) begin
            o_result.address = n_sum + {16'h0000, n_value};
            o_result.invalid = 1'b0;
        end else begin
            o_result.address = '0;
            o_result.invalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.final_char)) begin
            r_value   <= '0;
            r_number  <= '0;
            r_stopped <= 1'b0;
            r_sum     <= '0;
            r_chars   <= '0;
        end else if (i_step) begin
            r_value   <= n_value;
            r_number  <= n_number;
            r_stopped <= n_stopped;
            r_sum     <= n_sum;
            r_chars   <= n_chars;
        end
    end

endmodule

@@ rtl/ipv4p_out_stage.sv @@
// Result register on the output channel.
module ipv4p_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ipv4p_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output ipv4p_pkg::t_result o_result
);
    import ipv4p_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Empty, or the held result is transferred this cycle.
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/ipv4_dotted_text_parser.sv @@
// Top level of the dotted-decimal IPv4 text parser.
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  ---------------------------
//  chars    in         i_valid / o_stall   i_text_char, i_final_char
//  result   out        o_valid / i_stall   o_address, o_invalid
//
// One character per cycle is taken unless a last character waits on a full result
// register; the limit is the core's combinational times-ten add and address sum.
// A last character is held in the input register, then its result loads the
// result register and raises o_valid once that register is free.
// Reset is synchronous, active low, and clears all text state.
// A stall on the result side holds o_stall only while a last character waits
// to load a full result register; other characters keep flowing.
module ipv4_dotted_text_parser #(
    parameter int MAX_CHARS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_char,
    input  logic        i_final_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_address,
    output logic        o_invalid
);
    import ipv4p_pkg::*;

    t_item   in_item;
    t_item   held_item;
    t_result core_result;
    t_result out_result;
    logic    in_full;
    logic    out_free;
    logic    step;
    logic    load_result;

    assign in_item.text_char  = i_text_char;
    assign in_item.final_char = i_final_char;

    // A non-final character never needs the output register, so it always moves.
    assign step        = in_full && (!held_item.final_char || out_free);
    assign load_result = step && held_item.final_char;

    ipv4p_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (step),
        .o_stall (o_stall),
        .o_full  (in_full),
        .o_item  (held_item)
    );

    ipv4p_core #(
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (held_item),
        .o_result (core_result)
    );

    ipv4p_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load_result),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_address = out_result.address;
    assign o_invalid = out_result.invalid;

`ifndef SYNTHESIS
    // An invalid text always reports a zero address.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> (o_address == 32'h0))
        else $error("invalid result with nonzero address");

    // A last character that moves through the core produces a result next cycle.
    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_result |=> o_valid)
        else $error("last character did not produce a result");

    // An empty result register never holds off the input side.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with result register empty");
`endif

endmodule
